@@ rtl/tma_pkg.sv @@
package tma_pkg;

    localparam int WINDOW_MAX  = 64;
    localparam int SAMPLE_BITS = 16;
    localparam int CFG_BITS    = 7;

    localparam int PTR_BITS = $clog2(WINDOW_MAX);
    localparam int LEN_BITS = $clog2(WINDOW_MAX + 1);
    localparam int SUM_BITS = SAMPLE_BITS + LEN_BITS;
    localparam int MAG_BITS = SUM_BITS - 1;
    localparam int CNT_BITS = $clog2(MAG_BITS + 1);
    localparam int LIM_BITS = (LEN_BITS > CFG_BITS) ? LEN_BITS : CFG_BITS;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] sample;
        logic [PTR_BITS-1:0]    wr_ptr;
        logic [LEN_BITS-1:0]    len;
    } t_win_req;

endpackage

@@ rtl/tma_if.sv @@
interface tma_in_if import tma_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] sample;
    logic                   first_sample;

    modport source (output valid, output sample, output first_sample, input ready);
    modport sink   (input valid, input sample, input first_sample, output ready);
endinterface

interface tma_out_if import tma_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] average;

    modport source (output valid, output average, input ready);
    modport sink   (input valid, input average, output ready);
endinterface

@@ rtl/tma_window.sv @@
module tma_window import tma_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  t_win_req            i_req,
    output logic                o_done,
    output logic [SUM_BITS-1:0] o_sum
);

    typedef enum logic [2:0] {
        W_IDLE  = 3'b001,
        W_READ  = 3'b010,
        W_DRAIN = 3'b100
    } t_win_state;

    t_win_state             r_state, n_state;
    logic [SAMPLE_BITS-1:0] r_mem [WINDOW_MAX];
    logic [SAMPLE_BITS-1:0] r_rd_data;
    logic                   r_rd_vld;
    logic [PTR_BITS-1:0]    r_ptr;
    logic [LEN_BITS-1:0]    r_left;
    logic [SUM_BITS-1:0]    r_sum;
    logic                   r_done;
    logic                   w_take;

    assign w_take = i_start && (r_state == W_IDLE);

    always_comb begin
        n_state = r_state;
        case (r_state)
            W_IDLE:  if (i_start) n_state = W_READ;
            W_READ:  if (r_left == LEN_BITS'(1)) n_state = W_DRAIN;
            W_DRAIN: n_state = W_IDLE;
            default: n_state = W_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_mem[i_req.wr_ptr] <= i_req.sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == W_READ) begin
            r_rd_data <= r_mem[r_ptr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= W_IDLE;
            r_rd_vld <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= (r_state == W_READ);
            r_done   <= (r_state == W_DRAIN);
        end
    end

    // newest entry first, walking back through the delay line
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_ptr  <= i_req.wr_ptr;
            r_left <= i_req.len;
            r_sum  <= '0;
        end else begin
            if (r_state == W_READ) begin
                r_ptr  <= (r_ptr == '0) ? PTR_BITS'(WINDOW_MAX - 1) : r_ptr - 1'b1;
                r_left <= r_left - 1'b1;
            end
            if (r_rd_vld) begin
                r_sum <= r_sum + {{(SUM_BITS-SAMPLE_BITS){r_rd_data[SAMPLE_BITS-1]}},
                                  r_rd_data};
            end
        end
    end

    assign o_done = r_done;
    assign o_sum  = r_sum;

endmodule

@@ rtl/tma_div.sv @@
module tma_div import tma_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [SUM_BITS-1:0]    i_sum,
    input  logic [LEN_BITS-1:0]    i_len,
    output logic                   o_done,
    output logic [SAMPLE_BITS-1:0] o_quot
);

    logic                r_busy;
    logic                r_done;
    logic                r_neg;
    logic [CNT_BITS-1:0] r_cnt;
    logic [MAG_BITS-1:0] r_q;
    logic [LEN_BITS-1:0] r_rem;
    logic [LEN_BITS-1:0] r_div;
    logic [SUM_BITS-1:0] w_abs;
    logic [LEN_BITS:0]   w_trial;
    logic [LEN_BITS:0]   w_diff;
    logic                w_ge;
    logic [MAG_BITS-1:0] w_quot;

    assign w_abs   = i_sum[SUM_BITS-1] ? (~i_sum + 1'b1) : i_sum;
    assign w_trial = {r_rem, r_q[MAG_BITS-1]};
    assign w_diff  = w_trial - {1'b0, r_div};
    assign w_ge    = (w_trial >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_cnt == CNT_BITS'(1))) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // restoring division on the magnitude, one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_sum[SUM_BITS-1];
            r_q   <= w_abs[MAG_BITS-1:0];
            r_rem <= '0;
            r_div <= i_len;
            r_cnt <= CNT_BITS'(MAG_BITS);
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[LEN_BITS-1:0] : w_trial[LEN_BITS-1:0];
            r_q   <= {r_q[MAG_BITS-2:0], w_ge};
            r_cnt <= r_cnt - 1'b1;
        end
    end

    assign w_quot = r_neg ? (~r_q + 1'b1) : r_q;
    assign o_done = r_done;
    assign o_quot = w_quot[SAMPLE_BITS-1:0];

endmodule

@@ rtl/trailing_moving_average.sv @@
// Each item is summed over len delay-line entries and then divided by len, where
//   len = max(1, min(index, window_length)), so 1 to 64.
// One item in flight at a time: input ready only when idle; the window sum reads one delay-line
//   entry per cycle and the divider produces one quotient bit per cycle.
// Reset: synchronous; control state, index, write pointer cleared, window_length = 1.
//   The delay line is not cleared.
module trailing_moving_average import tma_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [CFG_BITS-1:0] i_cfg_wdata,
    tma_in_if.sink              i_in,
    tma_out_if.source           o_out
);

    typedef enum logic [3:0] {
        T_IDLE = 4'b0001,
        T_SUM  = 4'b0010,
        T_DIV  = 4'b0100,
        T_PUT  = 4'b1000
    } t_top_state;

    t_top_state             r_state, n_state;
    logic [CFG_BITS-1:0]    r_win_len;
    logic [LEN_BITS-1:0]    r_idx;
    logic [PTR_BITS-1:0]    r_wr_ptr;
    logic [LEN_BITS-1:0]    r_len;
    logic                   r_out_vld;
    logic [SAMPLE_BITS-1:0] r_out_avg;

    logic                   w_accept;
    logic [LEN_BITS-1:0]    w_n;
    logic [LIM_BITS-1:0]    w_cfg_ext;
    logic [LIM_BITS-1:0]    w_lim;
    logic [LIM_BITS-1:0]    w_n_ext;
    logic [LIM_BITS-1:0]    w_len_ext;
    logic [LEN_BITS-1:0]    w_len;
    t_win_req               w_req;
    logic                   w_win_done;
    logic [SUM_BITS-1:0]    w_sum;
    logic                   w_div_start;
    logic                   w_div_done;
    logic [SAMPLE_BITS-1:0] w_quot;
    logic                   w_out_free;
    logic                   w_load;

    assign i_in.ready = (r_state == T_IDLE);
    assign w_accept   = i_in.valid && i_in.ready;

    always_comb begin
        w_n       = i_in.first_sample ? '0 : r_idx;
        w_cfg_ext = LIM_BITS'(r_win_len);
        w_lim     = (w_cfg_ext > LIM_BITS'(WINDOW_MAX)) ? LIM_BITS'(WINDOW_MAX) : w_cfg_ext;
        w_n_ext   = LIM_BITS'(w_n);
        w_len_ext = (w_n_ext < w_lim) ? w_n_ext : w_lim;
        if (w_len_ext == '0) begin
            w_len_ext = LIM_BITS'(1);
        end
        w_len = w_len_ext[LEN_BITS-1:0];
    end

    assign w_req.sample = i_in.sample;
    assign w_req.wr_ptr = r_wr_ptr;
    assign w_req.len    = w_len;

    tma_window u_window (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_accept),
        .i_req   (w_req),
        .o_done  (w_win_done),
        .o_sum   (w_sum)
    );

    assign w_div_start = (r_state == T_SUM) && w_win_done;

    tma_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_sum   (w_sum),
        .i_len   (r_len),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    assign w_out_free = !r_out_vld || o_out.ready;
    assign w_load     = w_out_free &&
                        (((r_state == T_DIV) && w_div_done) || (r_state == T_PUT));

    always_comb begin
        n_state = r_state;
        case (r_state)
            T_IDLE:  if (w_accept) n_state = T_SUM;
            T_SUM:   if (w_win_done) n_state = T_DIV;
            T_DIV:   if (w_div_done) n_state = w_out_free ? T_IDLE : T_PUT;
            T_PUT:   if (w_out_free) n_state = T_IDLE;
            default: n_state = T_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= T_IDLE;
            r_win_len <= CFG_BITS'(1);
            r_idx     <= '0;
            r_wr_ptr  <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_win_len <= i_cfg_wdata;
            end
            if (w_accept) begin
                r_idx    <= (w_n < LEN_BITS'(WINDOW_MAX)) ? w_n + 1'b1
                                                          : LEN_BITS'(WINDOW_MAX);
                r_wr_ptr <= (r_wr_ptr == PTR_BITS'(WINDOW_MAX - 1)) ? '0
                                                                    : r_wr_ptr + 1'b1;
            end
            if (w_load) begin
                r_out_vld <= 1'b1;
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_len <= w_len;
        end
        if (w_load) begin
            r_out_avg <= w_quot;
        end
    end

    assign o_out.valid   = r_out_vld;
    assign o_out.average = r_out_avg;

    a_busy_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !i_in.ready)
        else $error("input ready while an item is in flight");

    a_win_done_in_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_win_done |-> (r_state == T_SUM))
        else $error("window sum finished outside the sum phase");

    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == T_DIV))
        else $error("divider finished outside the divide phase");

    a_out_from_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out.valid) |-> $past((r_state == T_DIV) || (r_state == T_PUT)))
        else $error("output valid without a finished quotient");

    a_idx_saturates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= LEN_BITS'(WINDOW_MAX))
        else $error("series index beyond the window maximum");

endmodule
